// ===== design/uud_pkg.sv =====
package uud_pkg;

	// result kinds on the output channel
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_BEGIN = 3'd1;
	localparam logic [2:0] ERR_HDR_OPEN = 3'd2;
	localparam logic [2:0] ERR_BAD_CNT  = 3'd3;
	localparam logic [2:0] ERR_TRUNC    = 3'd4;

	localparam logic [5:0] LIMIT_RESET = 6'd45;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_SP = 8'h20;

	// one queued job: up to three bytes, an end marker or an error
	typedef struct packed {
		logic [1:0]  kind;   // KIND_* code
		logic [1:0]  cnt;    // bytes valid for KIND_BYTE, 1..3
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [2:0]  err;
		logic [31:0] total;
	} job_t;

endpackage

// ===== design/uud_fifo.sv =====
module uud_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uud_pkg::job_t   wr_job,
	input  logic            pop,
	output uud_pkg::job_t   rd_job,
	output logic            full,
	output logic            empty
);
	import uud_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== design/uud_front.sv =====
module uud_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [5:0]     cfg_wr_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_char,
	input  logic           in_last,
	input  logic           q_full,
	output logic           q_push,
	output uud_pkg::job_t  q_job
);
	import uud_pkg::*;

	localparam logic [2:0] M_SEARCH = 3'd0;
	localparam logic [2:0] M_HEADER = 3'd1;
	localparam logic [2:0] M_COUNT  = 3'd2;
	localparam logic [2:0] M_DATA   = 3'd3;
	localparam logic [2:0] M_DONE   = 3'd4;
	localparam logic [2:0] M_ERROR  = 3'd5;

	localparam logic [2:0] KW_LEN = 3'd5;

	logic [5:0]  limit_q;
	logic [2:0]  mode_q, mode_d;
	logic [2:0]  match_q, match_d;
	logic [5:0]  left_q, left_d;
	logic [17:0] sext_q, sext_d;
	logic [1:0]  pos_q, pos_d;
	logic [31:0] count_q, count_d;
	logic [2:0]  err_q, err_d;

	logic        accept;
	logic        eol;
	logic [5:0]  six;
	logic [5:0]  take;
	logic [2:0]  match_step;
	job_t        job;
	logic        job_vld;

	function automatic logic [7:0] kw_char(input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		unique case (i)
			3'd0:    c = 8'h62;   // b
			3'd1:    c = 8'h65;   // e
			3'd2:    c = 8'h67;   // g
			3'd3:    c = 8'h69;   // i
			3'd4:    c = 8'h6E;   // n
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign eol      = (in_char == CHAR_CR) || (in_char == CHAR_LF);
	assign six      = 6'(in_char - CHAR_SP);
	assign take     = (left_q < 6'd3) ? left_q : 6'd3;

	always_comb begin
		if (match_q < KW_LEN && in_char == kw_char(match_q)) begin
			match_step = match_q + 1'b1;
		end else begin
			match_step = (in_char == kw_char(3'd0)) ? 3'd1 : 3'd0;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		match_d = match_q;
		left_d  = left_q;
		sext_d  = sext_q;
		pos_d   = pos_q;
		count_d = count_q;
		err_d   = err_q;
		job_vld = 1'b0;
		job     = '0;
		job.b0  = {sext_q[17:12], sext_q[11:10]};
		job.b1  = {sext_q[9:6], sext_q[5:2]};
		job.b2  = {sext_q[1:0], six};
		unique case (mode_q)
			M_ERROR: begin
				job_vld  = 1'b1;
				job.kind = KIND_ERR;
				job.err  = err_q;
			end
			M_SEARCH: begin
				if (match_step == KW_LEN) begin
					match_d = '0;
					mode_d  = M_HEADER;
				end else begin
					match_d = match_step;
				end
				if (in_last) begin
					err_d = ERR_NO_BEGIN;
				end
			end
			M_HEADER: begin
				if (in_last) begin
					err_d = eol ? ERR_TRUNC : ERR_HDR_OPEN;
				end else if (eol) begin
					mode_d = M_COUNT;
				end
			end
			M_COUNT: begin
				if (eol) begin
					if (in_last) begin
						err_d = ERR_TRUNC;
					end
				end else if (six == '0) begin
					mode_d    = M_DONE;
					job_vld   = 1'b1;
					job.kind  = KIND_END;
					job.total = count_q;
				end else if (six > limit_q) begin
					err_d = ERR_BAD_CNT;
				end else if (in_last) begin
					err_d = ERR_TRUNC;
				end else begin
					left_d = six;
					sext_d = '0;
					pos_d  = '0;
					mode_d = M_DATA;
				end
			end
			M_DATA: begin
				if (in_last) begin
					err_d = ERR_TRUNC;
				end else if (pos_q == 2'd3) begin
					job_vld  = 1'b1;
					job.kind = KIND_BYTE;
					job.cnt  = take[1:0];
					left_d   = left_q - take;
					count_d  = count_q + 32'(take);
					sext_d   = '0;
					pos_d    = '0;
					if (left_q == take) begin
						mode_d = M_COUNT;
					end
				end else begin
					sext_d = {sext_q[11:0], six};
					pos_d  = pos_q + 1'b1;
				end
			end
			default: ;
		endcase
		// a new error code produces one error result and locks the decoder
		if (err_d != err_q) begin
			mode_d   = M_ERROR;
			job_vld  = 1'b1;
			job      = '0;
			job.kind = KIND_ERR;
			job.err  = err_d;
		end
	end

	assign q_push = accept && job_vld;
	assign q_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			mode_q  <= M_SEARCH;
			match_q <= '0;
			left_q  <= '0;
			sext_q  <= '0;
			pos_q   <= '0;
			count_q <= '0;
			err_q   <= ERR_NONE;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				mode_q  <= mode_d;
				match_q <= match_d;
				left_q  <= left_d;
				sext_q  <= sext_d;
				pos_q   <= pos_d;
				count_q <= count_d;
				err_q   <= err_d;
			end
		end
	end

	a_err_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |-> (mode_q == M_ERROR)) else $error("error without lock");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_ERROR) |=> (mode_q == M_ERROR) && $stable(err_q))
		else $error("sticky error changed");
	a_data_owes: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_DATA) |-> (left_q != '0)) else $error("data line owes nothing");

endmodule

// ===== design/uud_back.sv =====
module uud_back (
	input  logic           clk,
	input  logic           arst_n,
	input  uud_pkg::job_t  q_job,
	input  logic           q_empty,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_kind,
	output logic [7:0]     out_byte,
	output logic [2:0]     error_code,
	output logic [31:0]    total_bytes,
	output logic           run_last
);
	import uud_pkg::*;

	logic [1:0]  idx_q;
	logic [1:0]  last_idx;
	logic        is_last;
	logic        load;
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [2:0]  err_q;
	logic [31:0] total_q;
	logic        last_q;
	logic [7:0]  sel_byte;

	assign last_idx = (q_job.kind == KIND_BYTE) ? q_job.cnt - 1'b1 : 2'd0;
	assign is_last  = (idx_q == last_idx);
	assign load     = (!valid_q || out_ready) && !q_empty;
	assign q_pop    = load && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = q_job.b0;
			2'd1:    sel_byte = q_job.b1;
			default: sel_byte = q_job.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= q_job.kind;
			byte_q  <= (q_job.kind == KIND_BYTE) ? sel_byte : 8'd0;
			err_q   <= (q_job.kind == KIND_ERR) ? q_job.err : ERR_NONE;
			total_q <= (q_job.kind == KIND_END) ? q_job.total : 32'd0;
			last_q  <= is_last;
		end
	end

	assign out_valid   = valid_q;
	assign out_kind    = kind_q;
	assign out_byte    = byte_q;
	assign error_code  = err_q;
	assign total_bytes = total_q;
	assign run_last    = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !q_empty && (q_job.kind == KIND_BYTE))
		else $error("byte index without byte job");
	a_err_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_ERR) |-> (err_q != ERR_NONE))
		else $error("error result without code");
	a_nonbyte_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q != KIND_BYTE) |-> last_q)
		else $error("end or error result not flagged last");

endmodule

// ===== design/uudecode_stream.sv =====
// channel   dir  handshake               payload
// in        in   in_valid / in_ready     in_char, in_last
// out       out  out_valid / out_ready   out_kind, out_byte, error_code, total_bytes, run_last
// cfg       in   cfg_wr_en               cfg_wr_data (line byte limit)
//
// One character is taken per cycle while the job queue has room; the decoder
// state advances in the cycle of the transfer.
// Results leave one per cycle from the output register while out_ready is high and the
// queue holds a job; a four-character group makes up to three byte results, so the
// queue (QUEUE_DEPTH jobs) absorbs bursts on their way to the output register.
// arst_n clears the decoder state, the queue and the output valid flag, not the output data.
module uudecode_stream #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_char,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [2:0]  error_code,
	output logic [31:0] total_bytes,
	output logic        run_last
);
	import uud_pkg::*;

	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic full;
	logic empty;

	uud_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.in_last     (in_last),
		.q_full      (full),
		.q_push      (push),
		.q_job       (push_job)
	);

	uud_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.full   (full),
		.empty  (empty)
	);

	uud_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_job       (head_job),
		.q_empty     (empty),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.error_code  (error_code),
		.total_bytes (total_bytes),
		.run_last    (run_last)
	);

endmodule

// ===== bench/uudecode_stream_test.sv =====
`timescale 1ns / 100ps

module uudecode_stream_test;
	import uud_pkg::*;

	localparam logic [39:0] KEYWORD = "begin";
	localparam logic [7:0] CHAR_B = "b";
	localparam logic [7:0] CHAR_ALL_ONES = "_";   // sextet 63
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 200;
	localparam int TAIL_CYCLES = 20;

	typedef enum logic [2:0] {
		DEC_SEARCH, DEC_HEADER, DEC_COUNT, DEC_DATA, DEC_DONE, DEC_ERROR
	} dec_mode_e;

	typedef enum logic [2:0] {
		STOP_ZERO_LAST, STOP_ZERO, STOP_BAD_COUNT, STOP_TRUNC_DATA, STOP_TRUNC_EOL,
		STOP_TRUNC_COUNT
	} stream_stop_e;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [2:0]  err;
		logic [31:0] total;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [5:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_char = '0;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [2:0]  error_code;
	logic [31:0] total_bytes;
	logic        run_last;

	// decoder shadow state
	dec_mode_e   dec_mode = DEC_SEARCH;
	logic [2:0]  match_idx = '0;
	logic [5:0]  owed = '0;
	logic [17:0] sextets = '0;
	logic [1:0]  grp_pos = '0;
	logic [31:0] byte_total = '0;
	logic [2:0]  sticky_err = ERR_NONE;
	logic [5:0]  byte_limit = LIMIT_RESET;

	result_t      pending_results[$];
	stream_stop_e stop_kind;
	int           chars_sent = 0;
	int           results_seen = 0;
	int           mismatches = 0;
	int           hold_len = 0;
	int           quiet_cycles = 0;
	bit           send_burst = 1'b0;
	bit           recv_burst = 1'b0;
	bit           send_quick = 1'b0;

	uudecode_stream dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_char(in_char),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.error_code(error_code),
		.total_bytes(total_bytes),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] data,
			input logic [2:0] err, input logic [31:0] total);
		result_t r;
		r.kind = kind;
		r.data = data;
		r.err = err;
		r.total = total;
		r.last = 1'b0;
		return r;
	endfunction

	// advance the shadow decoder by one character and queue what it emits
	task automatic decode_char(input logic [7:0] c, input logic last);
		result_t res [3];
		logic [7:0] trio [3];
		logic [5:0] six;
		logic [2:0] raised;
		logic eol;
		int n;
		int take;
		n = 0;
		raised = ERR_NONE;
		six = 6'(c - CHAR_SP);
		eol = (c == CHAR_CR) || (c == CHAR_LF);
		case (dec_mode)
		DEC_ERROR: begin
			res[0] = make_result(KIND_ERR, 8'd0, sticky_err, 32'd0);
			n = 1;
		end
		DEC_SEARCH: begin
			if (match_idx < 5 && c == KEYWORD[39 - 8 * match_idx -: 8])
				match_idx++;
			else
				match_idx = (c == CHAR_B) ? 3'd1 : 3'd0;
			if (match_idx == 5) begin
				match_idx = '0;
				dec_mode = DEC_HEADER;
			end
			if (last)
				raised = ERR_NO_BEGIN;
		end
		DEC_HEADER: begin
			if (last)
				raised = eol ? ERR_TRUNC : ERR_HDR_OPEN;
			else if (eol)
				dec_mode = DEC_COUNT;
		end
		DEC_COUNT: begin
			if (eol) begin
				if (last)
					raised = ERR_TRUNC;
			end else if (six == 0) begin
				dec_mode = DEC_DONE;
				res[0] = make_result(KIND_END, 8'd0, ERR_NONE, byte_total);
				n = 1;
			end else if (six > byte_limit) begin
				raised = ERR_BAD_CNT;
			end else if (last) begin
				raised = ERR_TRUNC;
			end else begin
				owed = six;
				sextets = '0;
				grp_pos = '0;
				dec_mode = DEC_DATA;
			end
		end
		DEC_DATA: begin
			if (last) begin
				raised = ERR_TRUNC;
			end else if (grp_pos == 3) begin
				trio[0] = {sextets[17:12], sextets[11:10]};
				trio[1] = {sextets[9:6], sextets[5:2]};
				trio[2] = {sextets[1:0], six};
				take = (owed < 3) ? owed : 3;
				for (int i = 0; i < take; i++) begin
					res[n] = make_result(KIND_BYTE, trio[i], ERR_NONE, 32'd0);
					n++;
				end
				owed = owed - 6'(take);
				byte_total = byte_total + take;
				sextets = '0;
				grp_pos = '0;
				if (owed == 0)
					dec_mode = DEC_COUNT;
			end else begin
				sextets = {sextets[11:0], six};
				grp_pos++;
			end
		end
		default: ;
		endcase
		if (raised != ERR_NONE) begin
			dec_mode = DEC_ERROR;
			sticky_err = raised;
			res[0] = make_result(KIND_ERR, 8'd0, raised, 32'd0);
			n = 1;
		end
		if (n > 0)
			res[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(res[i]);
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		if ($urandom_range(0, 19) == 0)
			send_burst = !send_burst;
		gap = (send_burst || send_quick) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		in_last <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		decode_char(c, last);
		chars_sent++;
	endtask

	// length character for n, with random upper bits that still decode to n
	function automatic logic [7:0] count_char(input int n);
		logic [7:0] c;
		c = 8'(n + 32 + 64 * $urandom_range(0, 3));
		if (c == CHAR_CR || c == CHAR_LF)
			c = 8'(n + 32);
		return c;
	endfunction

	// fill < 0 gives random data characters
	task automatic send_line(input int count, input int fill);
		int groups;
		groups = (count + 2) / 3;
		send_char(count_char(count), 1'b0);
		for (int i = 0; i < 4 * groups; i++)
			send_char(8'(fill < 0 ? $urandom_range(0, 255) : fill), 1'b0);
	endtask

	task automatic send_eols(input int k);
		for (int i = 0; i < k; i++)
			send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, 1'b0);
	endtask

	// limit changes only once the decoder has drained
	task automatic set_line_limit(input int value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= 6'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		byte_limit = 6'(value);
	endtask

	task automatic test_begin_search();
		string probe;
		logic [7:0] c;
		probe = "bebbegixbbegin";
		repeat (6) begin
			c = 8'($urandom_range(0, 255));
			if (c == CHAR_B)
				c = 8'h00;
			send_char(c, 1'b0);
		end
		for (int i = 0; i < probe.len(); i++)
			send_char(probe[i], 1'b0);
	endtask

	task automatic test_header_skip();
		logic [7:0] c;
		send_char(CHAR_SP, 1'b0);
		repeat (4) begin
			c = 8'($urandom_range(0, 255));
			if (c == CHAR_CR || c == CHAR_LF)
				c = CHAR_SP;
			send_char(c, 1'b0);
		end
		send_char(CHAR_CR, 1'b0);
		send_char(CHAR_LF, 1'b0);
	endtask

	task automatic test_short_lines();
		send_line(1, -1);
		send_eols(1);
		send_line(2, CHAR_SP);
		send_eols(2);
		send_line(3, CHAR_ALL_ONES);
		// no line break: next length character follows the data directly
		send_line(4, -1);
		send_eols(1);
	endtask

	task automatic test_eol_in_data();
		send_char(count_char(3), 1'b0);
		send_char(CHAR_CR, 1'b0);
		send_char(CHAR_LF, 1'b0);
		send_char(CHAR_CR, 1'b0);
		send_char(CHAR_LF, 1'b0);
		send_line(5, -1);
		send_eols(3);
	endtask

	task automatic test_backpressure();
		send_quick = 1'b1;
		hold_len = HOLD_CYCLES;
		send_line(byte_limit, -1);
		send_eols(2);
		send_line(12, -1);
		send_eols(1);
		send_quick = 1'b0;
	endtask

	task automatic test_random_lines();
		int start;
		int lines;
		int n;
		start = chars_sent;
		lines = 0;
		while (chars_sent - start < 50) begin
			if (lines % 2 == 0) begin
				case (lines / 2)
				0: set_line_limit(63);
				1: set_line_limit(1);
				default: set_line_limit($urandom_range(0, 3) == 0 ? 63 : $urandom_range(1, 63));
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				n = byte_limit;
			else
				n = $urandom_range(1, byte_limit < 12 ? byte_limit : 12);
			send_line(n, -1);
			send_eols($urandom_range(0, 3));
			lines++;
		end
	endtask

	task automatic test_stream_end();
		int n;
		int k;
		stop_kind = stream_stop_e'($urandom_range(0, 5));
		case (stop_kind)
		STOP_ZERO_LAST: send_char(count_char(0), 1'b1);
		STOP_ZERO: send_char(count_char(0), 1'b0);
		STOP_BAD_COUNT: begin
			if (byte_limit == 63)
				set_line_limit($urandom_range(1, 62));
			send_char(count_char($urandom_range(byte_limit + 1, 63)),
				1'($urandom_range(0, 1)));
		end
		STOP_TRUNC_DATA: begin
			n = $urandom_range(1, byte_limit);
			k = $urandom_range(0, 4 * ((n + 2) / 3) - 1);
			send_char(count_char(n), 1'b0);
			repeat (k) send_char(8'($urandom_range(0, 255)), 1'b0);
			send_char(8'($urandom_range(0, 255)), 1'b1);
		end
		STOP_TRUNC_EOL: send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, 1'b1);
		default: send_char(count_char($urandom_range(1, byte_limit)), 1'b1);
		endcase
		// ignored after the end marker; sticky error code otherwise
		repeat (8) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d byte %h err %0d",
				out_kind, out_byte, error_code));
		end else begin
			want = pending_results.pop_front();
			results_seen++;
			if (out_kind !== want.kind)
				report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
			if (out_byte !== want.data)
				report_mismatch($sformatf("byte %h, want %h", out_byte, want.data));
			if (error_code !== want.err)
				report_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
			if (total_bytes !== want.total)
				report_mismatch($sformatf("total_bytes %0d, want %0d", total_bytes, want.total));
			if (run_last !== want.last)
				report_mismatch($sformatf("run_last %b, want %b", run_last, want.last));
		end
	endtask

	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			if ($urandom_range(0, 19) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			check_result();
		end
	end

	// cycles without any transfer or register write
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_begin_search();
		test_header_skip();
		test_short_lines();
		test_eol_in_data();
		test_backpressure();
		test_random_lines();
		test_stream_end();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Decoded %0d bytes from %0d characters, %0d results compared, last limit %0d.",
			byte_total, chars_sent, results_seen, byte_limit);
		$display("Stream closed by %s, %0d mismatches.", stop_kind.name(), mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/uud_pkg.sv
design/uud_fifo.sv
design/uud_front.sv
design/uud_back.sv
design/uudecode_stream.sv
bench/uudecode_stream_test.sv
